[rtl/cbpe_pkg.sv]
// ----------------------------------------------------------------------------
// cbpe_pkg: shared constants and helpers for the ping-pong Bezier evaluator
// Opcodes, widths, divisor limits, micro-op tags and rounding functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cbpe_pkg;

    localparam int COORD_W = 32;
    localparam int CNT_W   = 13;
    localparam int T_W     = 16;
    localparam int WGT_W   = 31;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 64;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_SLIDE = 2'd2;

    localparam logic [CNT_W-1:0] DIV_MIN   = 13'd2;
    localparam logic [CNT_W-1:0] DIV_MAX   = 13'd4096;
    localparam logic [CNT_W-1:0] DIV_RESET = 13'd64;

    // what to do with the product once it is registered
    localparam logic [3:0] TG_NONE  = 4'd0;
    localparam logic [3:0] TG_TT    = 4'd1;
    localparam logic [3:0] TG_UU    = 4'd2;
    localparam logic [3:0] TG_W0    = 4'd3;
    localparam logic [3:0] TG_W1    = 4'd4;
    localparam logic [3:0] TG_W2    = 4'd5;
    localparam logic [3:0] TG_W3    = 4'd6;
    localparam logic [3:0] TG_LOAD  = 4'd7;
    localparam logic [3:0] TG_ADD   = 4'd8;
    localparam logic [3:0] TG_P1    = 4'd9;
    localparam logic [3:0] TG_FINAL = 4'd10;

    // Q.48 raw weight to Q.30, round half up
    function automatic logic [WGT_W-1:0] weight_round(input logic [PROD_W-1:0] raw);
        logic [48:0] sum;
        sum = raw[48:0] + 49'd131072;
        return sum[48:18];
    endfunction

    // Q.30 sum to coordinate: round half toward +inf, saturate to 32 bits
    function automatic logic [COORD_W-1:0] sat_round(input logic [ACC_W-1:0] s);
        logic [ACC_W-1:0]   b;
        logic signed [33:0] r;
        b = s + 64'd536870912;
        r = $signed(b[63:30]);
        if (r > 34'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (r < -34'sd2147483648)
            return 32'h8000_0000;
        else
            return r[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/cubic_bezier_pingpong_evaluator.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_pingpong_evaluator: cubic Bezier point on a ping-pong sweep
// Four 3D anchors, an up/down step counter, a restoring divider for t and
// one shared 34x32 multiplier that builds the weights and blends the curve.
// ----------------------------------------------------------------------------
//
//  channel   handshake              word
//  -------   ---------------------  ------------------------------------------
//  in        in_valid / in_stall    opcode, point_x, point_y, point_z
//  out       out_valid / out_stall  curve_x, curve_y, curve_z, step_index,
//                                   moving_down
//  cfg       cfg_wr_en              cfg_wr_data -> divisions
//
//  Push and slide are applied as they are accepted. A step runs from accept
//  through 16 divider iterations (one quotient bit a cycle), 6 weight
//  products and 18 blend slots on the shared multiplier, a drain and a
//  hand-over to a ready output word; the multiplier is what sets the length.
//  If the previous output word is still stalled, the hand-over waits for it.
//  Reset clears anchors, counter, direction and sets divisions to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_pingpong_evaluator (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic [cbpe_pkg::CNT_W-1:0]   cfg_wr_data,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   opcode,
    input  wire logic [cbpe_pkg::COORD_W-1:0] point_x,
    input  wire logic [cbpe_pkg::COORD_W-1:0] point_y,
    input  wire logic [cbpe_pkg::COORD_W-1:0] point_z,
    // output channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [cbpe_pkg::COORD_W-1:0]      curve_x,
    output logic [cbpe_pkg::COORD_W-1:0]      curve_y,
    output logic [cbpe_pkg::COORD_W-1:0]      curve_z,
    output logic [cbpe_pkg::CNT_W-1:0]        step_index,
    output logic                              moving_down
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_WGT   = 3'd2;
    localparam logic [2:0] S_BLEND = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // ---- state ---------------------------------------------------------------
    logic [2:0]                       state_reg, state_next;
    logic [3:0]                       ph_reg, ph_next;
    logic [1:0]                       cc_reg, cc_next;

    logic [cbpe_pkg::CNT_W-1:0]       divisions_reg;
    logic [cbpe_pkg::CNT_W-1:0]       cnt_reg;
    logic                             dir_reg;
    logic [cbpe_pkg::COORD_W-1:0]     anchor_reg [12];

    // divider
    logic [11:0]                      rem_reg;
    logic [cbpe_pkg::T_W-1:0]         q_reg;
    logic                             sat_reg;

    // multiplier and its consumers
    logic [cbpe_pkg::PROD_W-1:0]      prod_reg;
    logic [3:0]                       tag_reg, tag_next;
    logic [31:0]                      tt_reg;
    logic [32:0]                      uu_reg;
    logic [cbpe_pkg::WGT_W-1:0]       w_reg [4];
    logic [cbpe_pkg::ACC_W-1:0]       acc_reg;
    logic [cbpe_pkg::COORD_W-1:0]     p1_reg;
    logic [cbpe_pkg::COORD_W-1:0]     res_reg [3];

    // output word
    logic                             out_valid_reg;
    logic [cbpe_pkg::COORD_W-1:0]     curve_x_reg, curve_y_reg, curve_z_reg;
    logic [cbpe_pkg::CNT_W-1:0]       step_index_reg;
    logic                             moving_down_reg;

    // ---- combinational helpers -----------------------------------------------
    logic                             in_acc;
    logic                             out_load;
    logic [cbpe_pkg::CNT_W-1:0]       d_eff;
    logic [cbpe_pkg::CNT_W-1:0]       cnt_step;
    logic                             dir_step;
    logic                             slide_go;
    logic [12:0]                      rem_dbl;
    logic                             rem_ge;
    logic [12:0]                      rem_sub;
    logic [cbpe_pkg::T_W-1:0]         t_val;
    logic [16:0]                      u_val;
    logic [17:0]                      t3_val, u3_val;
    logic [3:0]                       anc_base;
    logic [3:0]                       anc_idx;
    logic [cbpe_pkg::COORD_W-1:0]     anc_rd;
    logic signed [cbpe_pkg::MUL_A_W-1:0] mul_a;
    logic signed [cbpe_pkg::MUL_B_W-1:0] mul_b;
    logic [cbpe_pkg::ACC_W-1:0]       blend_sum;
    logic [cbpe_pkg::WGT_W-1:0]       w_rnd;

    assign in_acc   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // divisions clamped to 2..4096
    assign d_eff = (divisions_reg < cbpe_pkg::DIV_MIN) ? cbpe_pkg::DIV_MIN :
                   (divisions_reg > cbpe_pkg::DIV_MAX) ? cbpe_pkg::DIV_MAX :
                   divisions_reg;

    // ping-pong move: down stops at zero, up wraps in 13 bits
    assign cnt_step = dir_reg ? ((cnt_reg != '0) ? cnt_reg - 13'd1 : 13'd0)
                              : cnt_reg + 13'd1;
    assign dir_step = (cnt_step == '0) ? 1'b0 :
                      (cnt_step >= d_eff - 13'd1) ? 1'b1 : dir_reg;

    assign slide_go = ({cnt_reg, 1'b0} > {1'b0, d_eff});

    // restoring divider, one quotient bit a cycle
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_ge  = (rem_dbl >= d_eff);
    assign rem_sub = rem_dbl - d_eff;

    assign t_val  = sat_reg ? 16'hFFFF : q_reg;
    assign u_val  = 17'h10000 - {1'b0, t_val};
    assign t3_val = {1'b0, t_val, 1'b0} + {2'b00, t_val};
    assign u3_val = {u_val, 1'b0} + {1'b0, u_val};

    // anchor k coordinate c sits at 3k+c
    always_comb
    begin
        case (ph_reg)
            4'd0:    anc_base = 4'd3;
            4'd1:    anc_base = 4'd6;
            4'd2:    anc_base = 4'd9;
            default: anc_base = 4'd0;
        endcase
    end
    assign anc_idx = anc_base + {2'b00, cc_reg};
    assign anc_rd  = anchor_reg[anc_idx];

    // ---- micro-op issue: operands and tag --------------------------------------
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        tag_next = cbpe_pkg::TG_NONE;
        case (state_reg)
            S_WGT:
            begin
                case (ph_reg)
                    4'd0:
                    begin
                        mul_a = {18'd0, t_val};  mul_b = {16'd0, t_val};
                        tag_next = cbpe_pkg::TG_TT;
                    end
                    4'd1:
                    begin
                        mul_a = {17'd0, u_val};  mul_b = {15'd0, u_val};
                        tag_next = cbpe_pkg::TG_UU;
                    end
                    4'd2:
                    begin
                        mul_a = {2'd0, tt_reg};  mul_b = {16'd0, t_val};
                        tag_next = cbpe_pkg::TG_W0;
                    end
                    4'd3:
                    begin
                        mul_a = {1'b0, uu_reg};  mul_b = {15'd0, u_val};
                        tag_next = cbpe_pkg::TG_W3;
                    end
                    4'd4:
                    begin
                        mul_a = {2'd0, tt_reg};  mul_b = {14'd0, u3_val};
                        tag_next = cbpe_pkg::TG_W1;
                    end
                    4'd5:
                    begin
                        mul_a = {1'b0, uu_reg};  mul_b = {14'd0, t3_val};
                        tag_next = cbpe_pkg::TG_W2;
                    end
                    default:
                    begin
                        tag_next = cbpe_pkg::TG_NONE;
                    end
                endcase
            end
            S_BLEND:
            begin
                case (ph_reg)
                    4'd0:
                    begin
                        mul_a = {{2{anc_rd[31]}}, anc_rd};  mul_b = {1'b0, w_reg[1]};
                        tag_next = cbpe_pkg::TG_LOAD;
                    end
                    4'd1:
                    begin
                        mul_a = {{2{anc_rd[31]}}, anc_rd};  mul_b = {1'b0, w_reg[2]};
                        tag_next = cbpe_pkg::TG_ADD;
                    end
                    4'd2:
                    begin
                        mul_a = {{2{anc_rd[31]}}, anc_rd};  mul_b = {1'b0, w_reg[3]};
                        tag_next = cbpe_pkg::TG_ADD;
                    end
                    4'd3:
                    begin
                        mul_a = {{2{anc_rd[31]}}, anc_rd};  mul_b = {1'b0, w_reg[0]};
                        tag_next = cbpe_pkg::TG_P1;
                    end
                    4'd5:
                    begin
                        mul_a = {{2{p1_reg[31]}}, p1_reg};  mul_b = {1'b0, w_reg[0]};
                        tag_next = cbpe_pkg::TG_FINAL;
                    end
                    default:
                    begin
                        tag_next = cbpe_pkg::TG_NONE;   // wait for P1
                    end
                endcase
            end
            default:
            begin
                tag_next = cbpe_pkg::TG_NONE;
            end
        endcase
    end

    // terms for A1..A3 stay in acc, so the second pass only adds P1*w0
    assign blend_sum = acc_reg + prod_reg[cbpe_pkg::ACC_W-1:0];
    assign w_rnd     = cbpe_pkg::weight_round(prod_reg);

    // ---- sequencer -------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        cc_next    = cc_reg;
        case (state_reg)
            S_IDLE:
            begin
                ph_next = '0;
                cc_next = '0;
                if (in_acc && (opcode == cbpe_pkg::OP_STEP))
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd15)
                    state_next = S_WGT;
            end
            S_WGT:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd5)
                begin
                    ph_next    = '0;
                    state_next = S_BLEND;
                end
            end
            S_BLEND:
            begin
                ph_next = ph_reg + 4'd1;
                if (ph_reg == 4'd5)
                begin
                    ph_next = '0;
                    cc_next = cc_reg + 2'd1;
                    if (cc_reg == 2'd2)
                        state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= '0;
            cc_reg    <= '0;
            tag_reg   <= cbpe_pkg::TG_NONE;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            cc_reg    <= cc_next;
            tag_reg   <= tag_next;
        end
    end

    // ---- architectural state: divisions, counter, anchors ----------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisions_reg <= cbpe_pkg::DIV_RESET;
            cnt_reg       <= '0;
            dir_reg       <= 1'b0;
            for (int i = 0; i < 12; i++)
                anchor_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                divisions_reg <= cfg_wr_data;
            if (in_acc)
            begin
                case (opcode)
                    cbpe_pkg::OP_PUSH:
                    begin
                        for (int i = 3; i < 12; i++)
                            anchor_reg[i] <= anchor_reg[i-3];
                        anchor_reg[0] <= point_x;
                        anchor_reg[1] <= point_y;
                        anchor_reg[2] <= point_z;
                    end
                    cbpe_pkg::OP_SLIDE:
                    begin
                        if (slide_go)
                        begin
                            for (int i = 0; i < 9; i++)
                                anchor_reg[i] <= anchor_reg[i+3];
                            anchor_reg[9]  <= anchor_reg[0];
                            anchor_reg[10] <= anchor_reg[1];
                            anchor_reg[11] <= anchor_reg[2];
                        end
                    end
                    cbpe_pkg::OP_STEP:
                    begin
                        cnt_reg <= cnt_step;
                        dir_reg <= dir_step;
                    end
                    default:
                    begin
                        cnt_reg <= cnt_reg;   // opcode three: no effect
                    end
                endcase
            end
        end
    end

    // ---- datapath --------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // divider
        if (in_acc)
        begin
            rem_reg <= cnt_step[11:0];
            q_reg   <= '0;
            sat_reg <= (cnt_step >= d_eff);
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= rem_ge ? rem_sub[11:0] : rem_dbl[11:0];
            q_reg   <= {q_reg[cbpe_pkg::T_W-2:0], rem_ge};
        end

        // shared multiplier, registered
        prod_reg <= cbpe_pkg::PROD_W'(mul_a * mul_b);

        // product consumers
        case (tag_reg)
            cbpe_pkg::TG_TT:   tt_reg   <= prod_reg[31:0];
            cbpe_pkg::TG_UU:   uu_reg   <= prod_reg[32:0];
            cbpe_pkg::TG_W0:   w_reg[0] <= w_rnd;
            cbpe_pkg::TG_W1:   w_reg[1] <= w_rnd;
            cbpe_pkg::TG_W2:   w_reg[2] <= w_rnd;
            cbpe_pkg::TG_W3:   w_reg[3] <= w_rnd;
            cbpe_pkg::TG_LOAD: acc_reg  <= prod_reg[cbpe_pkg::ACC_W-1:0];
            cbpe_pkg::TG_ADD:  acc_reg  <= blend_sum;
            cbpe_pkg::TG_P1:   p1_reg   <= cbpe_pkg::sat_round(blend_sum);
            cbpe_pkg::TG_FINAL:
            begin
                // x, y, z arrive in order and shift down
                res_reg[2] <= cbpe_pkg::sat_round(blend_sum);
                res_reg[1] <= res_reg[2];
                res_reg[0] <= res_reg[1];
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase

        if (out_load)
        begin
            curve_x_reg     <= res_reg[0];
            curve_y_reg     <= res_reg[1];
            curve_z_reg     <= res_reg[2];
            step_index_reg  <= cnt_reg;
            moving_down_reg <= dir_reg;
        end
    end

    // ---- output word valid -------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid   = out_valid_reg;
    assign curve_x     = curve_x_reg;
    assign curve_y     = curve_y_reg;
    assign curve_z     = curve_z_reg;
    assign step_index  = step_index_reg;
    assign moving_down = moving_down_reg;

    // ---- assertions ----------------------------------------------------------------
    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("output word raised outside hand-over");

    a_down_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dir_reg |-> (cnt_reg != '0))
        else $error("counting down from zero");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cbpe_pkg::DIV_MAX)
        else $error("step counter beyond largest division count");

    a_final_in_blend: assert property (@(posedge clk) disable iff (!rst_n)
        (tag_reg == cbpe_pkg::TG_FINAL) |-> (state_reg == S_BLEND || state_reg == S_DRAIN))
        else $error("final blend product outside blend phase");

endmodule

`default_nettype wire
